@@ src/dual_mic_bandpass_amplitude_detector_defines.svh @@
// Assertion macros shared by the detector RTL.
`ifndef DUAL_MIC_BANDPASS_AMPLITUDE_DETECTOR_DEFINES_SVH
`define DUAL_MIC_BANDPASS_AMPLITUDE_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DMBAD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define DMBAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/dmbad_pkg.sv @@
// Shared constants, types and register codes of the dual microphone detector.
`default_nettype none

package dmbad_pkg;

   // block framing
   localparam int BLOCK_LEN    = 1000;
   localparam int WINDOW_LEN   = 100;
   localparam int WINDOW_COUNT = 9;
   localparam int LANES        = 2;

   // field and state widths
   localparam int SAMPLE_W  = 14;
   localparam int CFG_W     = 16;
   localparam int AMP_W     = 16;
   localparam int SUM_W     = 24;
   localparam int STATE_W   = 32;
   localparam int IDX_W     = 10;
   localparam int SIDE_W    = 2;
   localparam int DEG_W     = 3;
   localparam int CSR_IDX_W = 3;

   // window position counter and index compare widths
   localparam int WPOS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int WIN_END = WINDOW_LEN * (WINDOW_COUNT + 1);
   localparam int CMP_W   = IDX_W + 5;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HIGH_PASS_GAIN,
      REG_LOW_PASS_GAIN,
      REG_DETECT_LEVEL,
      REG_DEAD_BAND,
      REG_DEGREE_STEP_ONE,
      REG_DEGREE_STEP_TWO,
      REG_DEGREE_STEP_THREE,
      REG_DEGREE_STEP_FOUR
   } csr_reg_type;

   typedef struct packed {
      logic [CFG_W-1:0] high_pass_gain;
      logic [CFG_W-1:0] low_pass_gain;
      logic [CFG_W-1:0] detect_level;
      logic [CFG_W-1:0] dead_band;
      logic [CFG_W-1:0] degree_step_one;
      logic [CFG_W-1:0] degree_step_two;
      logic [CFG_W-1:0] degree_step_three;
      logic [CFG_W-1:0] degree_step_four;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      high_pass_gain:    16'd58220,
      low_pass_gain:     16'd42819,
      detect_level:      16'd2482,
      dead_band:         16'd99,
      degree_step_one:   16'd248,
      degree_step_two:   16'd596,
      degree_step_three: 16'd993,
      degree_step_four:  16'd1489
   };

   // louder side codes
   typedef enum logic [SIDE_W-1:0] {
      SIDE_NONE,
      SIDE_TWO,
      SIDE_ONE
   } side_type;

   // per-item sequencer phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HIGH,
      PH_LOW
   } phase_type;

   // what one word does to the lane state
   typedef struct packed {
      logic filt_en;
      logic win_en;
      logic close;
      logic last;
   } item_type;

   // strobes from the sequencer to each lane
   typedef struct packed {
      logic     accept;
      logic     hp_step;
      logic     lp_step;
      item_type item;
   } lane_ctrl_type;

endpackage

`default_nettype wire

@@ src/dmbad_if.sv @@
// Handshake channels of the detector: sample words, result words, register writes.
`default_nettype none

interface dmbad_req_if import dmbad_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] mic_one_sample;
   logic [SAMPLE_W-1:0] mic_two_sample;

   modport source (output valid, output mic_one_sample, output mic_two_sample, input ready);
   modport sink   (input valid, input mic_one_sample, input mic_two_sample, output ready);
endinterface

interface dmbad_rsp_if import dmbad_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [AMP_W-1:0]  amp_one;
   logic [AMP_W-1:0]  amp_two;
   logic              sound_present;
   logic [SIDE_W-1:0] louder_side;
   logic [DEG_W-1:0]  turn_degree;

   modport source (output valid, output amp_one, output amp_two, output sound_present,
                   output louder_side, output turn_degree, input ready);
   modport sink   (input valid, input amp_one, input amp_two, input sound_present,
                   input louder_side, input turn_degree, output ready);
endinterface

interface dmbad_csr_if import dmbad_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CFG_W-1:0]     wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

@@ src/dmbad_lane.sv @@
// One microphone lane: high-pass and low-pass IIR, window peak-to-peak tracker and sum.
`default_nettype none

module dmbad_lane import dmbad_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctrl_type       ctrl,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [CFG_W-1:0]    hp_gain,
   input  logic [CFG_W-1:0]    lp_gain,
   output logic [SUM_W-1:0]    sum_out,
   output logic                fin
);

   localparam int FRAC   = 16;
   localparam int STEP_W = SAMPLE_W + 1;
   localparam int ACC_W  = STATE_W + 1;
   localparam int PROD_W = ACC_W + CFG_W + 1;
   localparam int RND_W  = PROD_W - FRAC;
   localparam int SAT_W  = RND_W + 1;
   localparam int CNT_W  = ACC_W - FRAC;
   localparam int HALF   = 1 << (FRAC - 1);

   // (p + half) >> 16, floor
   function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] biased;
      biased = p + PROD_W'(HALF);
      return biased[PROD_W-1:FRAC];
   endfunction

   // clamp to signed state range
   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SAT_W-1:0] v);
      if ((&v[SAT_W-1:STATE_W-1]) || !(|v[SAT_W-1:STATE_W-1])) begin
         return v[STATE_W-1:0];
      end else if (v[SAT_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

   logic [SAMPLE_W-1:0]       prev_ff;
   logic signed [PROD_W-1:0]  prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0]  prod_b_ff, prod_b_in;
   logic signed [STATE_W-1:0] hp_ff, hp_in;
   logic signed [STATE_W-1:0] lp_ff, lp_in;
   logic signed [STATE_W-1:0] win_v_ff, win_v_in;
   logic signed [STATE_W-1:0] max_ff, max_in;
   logic signed [STATE_W-1:0] min_ff, min_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [SUM_W-1:0]          sum_out_ff, sum_out_in;
   logic                      fin_ff, fin_in;
   logic                      w1_vld_ff;
   item_type                  w1_item_ff;
   logic                      w2_vld_ff;
   item_type                  w2_item_ff;

   logic signed [STEP_W-1:0]  step;
   logic signed [ACC_W-1:0]   acc_a;
   logic signed [STATE_W-1:0] hps;
   logic signed [ACC_W-1:0]   diff_b;
   logic signed [SAT_W-1:0]   lp_sum;
   logic signed [STATE_W-1:0] lp_new;
   logic signed [ACC_W-1:0]   amp;
   logic [ACC_W-1:0]          amp_biased;
   logic [CNT_W-1:0]          cnt;
   logic [SUM_W:0]            sum_wide;
   logic [SUM_W-1:0]          sum_closed;

   // high-pass product, taken at the accept edge
   always_comb begin
      step      = $signed({1'b0, sample}) - $signed({1'b0, prev_ff});
      acc_a     = ACC_W'(hp_ff) + (ACC_W'(step) <<< FRAC);
      prod_a_in = PROD_W'(acc_a) * PROD_W'($signed({1'b0, hp_gain}));
   end

   // high-pass result and low-pass product
   always_comb begin
      hps       = sat_state(SAT_W'(round_q16(prod_a_ff)));
      diff_b    = ACC_W'(hps) - ACC_W'(lp_ff);
      prod_b_in = PROD_W'(diff_b) * PROD_W'($signed({1'b0, lp_gain}));
   end

   // low-pass accumulate
   always_comb begin
      lp_sum = SAT_W'(lp_ff) + SAT_W'(round_q16(prod_b_ff));
      lp_new = sat_state(lp_sum);
   end

   // filter state: block end clears both
   always_comb begin
      hp_in    = hp_ff;
      lp_in    = lp_ff;
      win_v_in = win_v_ff;
      if (ctrl.hp_step && ctrl.item.filt_en) begin
         hp_in = hps;
      end
      if (ctrl.lp_step) begin
         win_v_in = ctrl.item.filt_en ? lp_new : lp_ff;
         if (ctrl.item.last) begin
            hp_in = '0;
            lp_in = '0;
         end else if (ctrl.item.filt_en) begin
            lp_in = lp_new;
         end
      end
   end

   // window close: rounded peak-to-peak into saturating sum
   always_comb begin
      amp        = ACC_W'(max_ff) - ACC_W'(min_ff);
      amp_biased = amp + ACC_W'(HALF);
      cnt        = amp_biased[ACC_W-1:FRAC];
      sum_wide   = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(cnt);
      sum_closed = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   end

   // window tracking in the w1 stage, then close in the w2 stage
   always_comb begin
      max_in     = max_ff;
      min_in     = min_ff;
      sum_in     = sum_ff;
      sum_out_in = sum_out_ff;
      fin_in     = 1'b0;
      if (w1_vld_ff && w1_item_ff.win_en) begin
         if (win_v_ff > max_ff) begin
            max_in = win_v_ff;
         end
         if (win_v_ff < min_ff) begin
            min_in = win_v_ff;
         end
      end
      if (w2_vld_ff) begin
         if (w2_item_ff.close) begin
            sum_in = sum_closed;
            max_in = '0;
            min_in = '0;
         end
         if (w2_item_ff.last) begin
            sum_out_in = w2_item_ff.close ? sum_closed : sum_ff;
            sum_in     = '0;
            fin_in     = 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         prev_ff   <= sample;
         prod_a_ff <= prod_a_in;
      end
      if (ctrl.hp_step) begin
         prod_b_ff <= prod_b_in;
      end
      if (ctrl.lp_step) begin
         w1_item_ff <= ctrl.item;
      end
      if (w1_vld_ff) begin
         w2_item_ff <= w1_item_ff;
      end
      win_v_ff   <= win_v_in;
      sum_out_ff <= sum_out_in;
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff     <= '0;
         lp_ff     <= '0;
         max_ff    <= '0;
         min_ff    <= '0;
         sum_ff    <= '0;
         fin_ff    <= 1'b0;
         w1_vld_ff <= 1'b0;
         w2_vld_ff <= 1'b0;
      end else begin
         hp_ff     <= hp_in;
         lp_ff     <= lp_in;
         max_ff    <= max_in;
         min_ff    <= min_in;
         sum_ff    <= sum_in;
         fin_ff    <= fin_in;
         w1_vld_ff <= ctrl.lp_step;
         w2_vld_ff <= w1_vld_ff;
      end
   end

   assign sum_out = sum_out_ff;
   assign fin     = fin_ff;

endmodule

`default_nettype wire

@@ src/dmbad_merge.sv @@
// Merge stage: divide both sums by ten, saturate, detect, pick side and turn degree.
`default_nettype none

module dmbad_merge import dmbad_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             fin,
   input  logic [SUM_W-1:0] sum_one,
   input  logic [SUM_W-1:0] sum_two,
   input  cfg_type          cfg,
   dmbad_rsp_if.source      rsp_bus
);

   // floor(n / 10) = (n * ceil(2^27 / 10)) >> 27, exact for 24-bit n
   localparam int               RECIP_SHIFT = SUM_W + 3;
   localparam logic [SUM_W-1:0] RECIP_TEN   = SUM_W'(((64'd1 << RECIP_SHIFT) / 10) + 1);
   localparam int               PROD_W      = 2 * SUM_W;
   localparam int               QUO_W       = PROD_W - RECIP_SHIFT;

   function automatic logic [AMP_W-1:0] amp_sat(input logic [QUO_W-1:0] q);
      return (|q[QUO_W-1:AMP_W]) ? {AMP_W{1'b1}} : q[AMP_W-1:0];
   endfunction

   logic [PROD_W-1:0] prod_one, prod_two;
   logic [QUO_W-1:0]  quo_one_ff, quo_two_ff;
   logic              m1_vld_ff;

   logic [AMP_W-1:0]  a1, a2;
   logic [AMP_W:0]    a1_plus, a2_plus;
   side_type          side_in;
   logic [AMP_W-1:0]  diff_in;
   logic [AMP_W-1:0]  a1_ff, a2_ff, diff_ff;
   logic              sound_ff;
   side_type          side_ff;
   logic              m2_vld_ff;

   logic [DEG_W-1:0]  deg_in;
   logic [AMP_W-1:0]  out_amp_one_ff, out_amp_two_ff;
   logic              out_sound_ff;
   side_type          out_side_ff;
   logic [DEG_W-1:0]  out_deg_ff;
   logic              out_vld_ff, out_vld_in;

   // reciprocal multiply
   assign prod_one = PROD_W'(sum_one) * PROD_W'(RECIP_TEN);
   assign prod_two = PROD_W'(sum_two) * PROD_W'(RECIP_TEN);

   // saturate and compare
   always_comb begin
      a1      = amp_sat(quo_one_ff);
      a2      = amp_sat(quo_two_ff);
      a1_plus = (AMP_W+1)'(a1) + (AMP_W+1)'(cfg.dead_band);
      a2_plus = (AMP_W+1)'(a2) + (AMP_W+1)'(cfg.dead_band);
      side_in = SIDE_NONE;
      diff_in = '0;
      if ((AMP_W+1)'(a2) > a1_plus) begin
         side_in = SIDE_TWO;
         diff_in = a2 - a1;
      end else if ((AMP_W+1)'(a1) > a2_plus) begin
         side_in = SIDE_ONE;
         diff_in = a1 - a2;
      end
   end

   // turn degree from the difference
   always_comb begin
      deg_in = '0;
      if (side_ff != SIDE_NONE) begin
         if (diff_ff > cfg.degree_step_four) begin
            deg_in = 3'd4;
         end else if (diff_ff > cfg.degree_step_three) begin
            deg_in = 3'd3;
         end else if (diff_ff > cfg.degree_step_two) begin
            deg_in = 3'd2;
         end else if (diff_ff > cfg.degree_step_one) begin
            deg_in = 3'd1;
         end
      end
   end

   // output word holds until taken
   always_comb begin
      out_vld_in = out_vld_ff;
      if (m2_vld_ff) begin
         out_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (fin) begin
         quo_one_ff <= prod_one[PROD_W-1:RECIP_SHIFT];
         quo_two_ff <= prod_two[PROD_W-1:RECIP_SHIFT];
      end
      if (m1_vld_ff) begin
         a1_ff    <= a1;
         a2_ff    <= a2;
         sound_ff <= (a1 > cfg.detect_level) || (a2 > cfg.detect_level);
         side_ff  <= side_in;
         diff_ff  <= diff_in;
      end
      if (m2_vld_ff) begin
         out_amp_one_ff <= a1_ff;
         out_amp_two_ff <= a2_ff;
         out_sound_ff   <= sound_ff;
         out_side_ff    <= side_ff;
         out_deg_ff     <= deg_in;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff  <= fin;
         m2_vld_ff  <= m1_vld_ff;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.amp_one       = out_amp_one_ff;
   assign rsp_bus.amp_two       = out_amp_two_ff;
   assign rsp_bus.sound_present = out_sound_ff;
   assign rsp_bus.louder_side   = out_side_ff;
   assign rsp_bus.turn_degree   = out_deg_ff;

endmodule

`default_nettype wire

@@ src/dual_mic_bandpass_amplitude_detector.sv @@
// Top level: sample sequencer, register file, two filter lanes and the merge stage.
`default_nettype none

// Each sample word (one 14-bit sample per microphone) goes to two identical lanes that
// run a high-pass then a low-pass first-order IIR and track the peak-to-peak amplitude
// in nine windows of 100 words after a 100-word settling stretch. For each word the
// high-pass multiply runs at the accept edge and the low-pass multiply in the next cycle,
// and the following word can be taken in the cycle after that; this chained pair of
// multiplies through each lane's filter state sets the sustained word rate. Every 1000th
// word ends a block and yields one result word (sums divided by ten, saturated, side and
// turn degree); all block state is then cleared. The last word of a block is held off
// while the previous result word has not been taken. Registers are written through the
// csr channel, which is always ready, and should only be written while no word is in
// flight.

`include "dual_mic_bandpass_amplitude_detector_defines.svh"

module dual_mic_bandpass_amplitude_detector import dmbad_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dmbad_req_if.sink   req_bus,
   dmbad_rsp_if.source rsp_bus,
   dmbad_csr_if.sink   csr_bus
);

   cfg_type          cfg_ff, cfg_in;
   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [WPOS_W-1:0] wpos_ff, wpos_in;
   item_type         item_ff, item_in;
   logic             result_pend_ff, result_pend_in;

   logic             accept;
   logic             cur_last;
   logic             wrap;
   lane_ctrl_type    lane_ctrl;

   logic [SAMPLE_W-1:0] lane_sample [LANES];
   logic [SUM_W-1:0]    lane_sum [LANES];
   logic [LANES-1:0]    lane_fin;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_reg_type'(csr_bus.reg_index))
            REG_HIGH_PASS_GAIN:    cfg_in.high_pass_gain    = csr_bus.wr_data;
            REG_LOW_PASS_GAIN:     cfg_in.low_pass_gain     = csr_bus.wr_data;
            REG_DETECT_LEVEL:      cfg_in.detect_level      = csr_bus.wr_data;
            REG_DEAD_BAND:         cfg_in.dead_band         = csr_bus.wr_data;
            REG_DEGREE_STEP_ONE:   cfg_in.degree_step_one   = csr_bus.wr_data;
            REG_DEGREE_STEP_TWO:   cfg_in.degree_step_two   = csr_bus.wr_data;
            REG_DEGREE_STEP_THREE: cfg_in.degree_step_three = csr_bus.wr_data;
            REG_DEGREE_STEP_FOUR:  cfg_in.degree_step_four  = csr_bus.wr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // word position within block and window
   assign cur_last = idx_ff >= IDX_W'(BLOCK_LEN - 1);
   assign wrap     = wpos_ff == WPOS_W'(WINDOW_LEN - 1);

   assign req_bus.ready = (phase_ff != PH_HIGH) && !(cur_last && result_pend_ff);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      item_in.filt_en = idx_ff != '0;
      item_in.win_en  = (idx_ff >= IDX_W'(WINDOW_LEN)) && (CMP_W'(idx_ff) < CMP_W'(WIN_END));
      item_in.close   = item_in.win_en && (wrap || cur_last);
      item_in.last    = cur_last;
   end

   always_comb begin
      idx_in  = idx_ff;
      wpos_in = wpos_ff;
      if (accept) begin
         idx_in  = cur_last ? '0 : idx_ff + IDX_W'(1);
         wpos_in = (cur_last || wrap) ? '0 : wpos_ff + WPOS_W'(1);
      end
   end

   // one result in flight at most
   always_comb begin
      result_pend_in = result_pend_ff;
      if (accept && cur_last) begin
         result_pend_in = 1'b1;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         result_pend_in = 1'b0;
      end
   end

   // sequencer next state and lane strobes
   always_comb begin
      phase_in          = phase_ff;
      lane_ctrl.accept  = accept;
      lane_ctrl.hp_step = 1'b0;
      lane_ctrl.lp_step = 1'b0;
      lane_ctrl.item    = item_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            lane_ctrl.hp_step = 1'b1;
            phase_in          = PH_LOW;
         end
         PH_LOW: begin
            lane_ctrl.lp_step = 1'b1;
            phase_in          = accept ? PH_HIGH : PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= CFG_RESET;
         idx_ff         <= '0;
         wpos_ff        <= '0;
         result_pend_ff <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         idx_ff         <= idx_in;
         wpos_ff        <= wpos_in;
         result_pend_ff <= result_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   // filter lanes
   assign lane_sample[0] = req_bus.mic_one_sample;
   assign lane_sample[1] = req_bus.mic_two_sample;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      dmbad_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .sample  (lane_sample[g]),
         .hp_gain (cfg_ff.high_pass_gain),
         .lp_gain (cfg_ff.low_pass_gain),
         .sum_out (lane_sum[g]),
         .fin     (lane_fin[g])
      );
   end

   // merge
   dmbad_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .fin     (&lane_fin),
      .sum_one (lane_sum[0]),
      .sum_two (lane_sum[1]),
      .cfg     (cfg_ff),
      .rsp_bus (rsp_bus)
   );

   `DMBAD_ASSERT_SAME(a_lanes_lockstep, lane_fin[0] || lane_fin[1], lane_fin[0] && lane_fin[1], "lanes finished a block on different cycles")
   `DMBAD_ASSERT_SAME(a_result_tracked, $rose(rsp_bus.valid), result_pend_ff, "result word without a finished block")
   `DMBAD_ASSERT_SAME(a_window_aligned, accept && (idx_ff == '0), wpos_ff == '0, "window counter not aligned to block start")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the dual microphone band-pass amplitude detector.
module tb import dmbad_pkg::*; ();

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 5 * BLOCK_LEN;
   localparam int REPORT_LIMIT  = 10;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
   localparam int AMP_MAX       = (1 << AMP_W) - 1;
   localparam int SUM_MAX       = (1 << SUM_W) - 1;
   localparam longint INT_HI    = 64'sd2147483647;
   localparam longint INT_LO    = -64'sd2147483648;

   // one block-end result word as the detector should report it
   typedef struct {
      int unsigned amp_one;
      int unsigned amp_two;
      bit          sound_present;
      side_type    louder_side;
      int unsigned turn_degree;
   } detection_type;

   // test signal of one microphone: square or sawtooth plus noise
   typedef struct {
      int period;
      int amp;
      int offset;
      int noise;
      int phase;
      bit square;
   } tone_type;

   logic clock;
   logic reset;

   dmbad_req_if req_bus();
   dmbad_rsp_if rsp_bus();
   dmbad_csr_if csr_bus();

   dual_mic_bandpass_amplitude_detector uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // detector state mirrored by the predictor
   cfg_type             active_cfg;
   logic [SAMPLE_W-1:0] last_sample [LANES];
   int                  hp_acc      [LANES];
   int                  lp_acc      [LANES];
   int                  peak_hi     [LANES];
   int                  peak_lo     [LANES];
   int unsigned         amp_total   [LANES];
   int unsigned         word_index;
   detection_type       pending_detections [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_cycles   = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint q16_round(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic int clip32(longint v);
      if (v > INT_HI) return int'(INT_HI);
      if (v < INT_LO) return int'(INT_LO);
      return int'(v);
   endfunction

   function void clear_tracking();
      for (int ch = 0; ch < LANES; ch++) begin
         last_sample[ch] = '0;
         hp_acc[ch]      = 0;
         lp_acc[ch]      = 0;
         peak_hi[ch]     = 0;
         peak_lo[ch]     = 0;
         amp_total[ch]   = 0;
      end
      word_index = 0;
   endfunction

   // high-pass then low-pass step of one lane, Q16 state
   function void filter_lane(int ch, logic [SAMPLE_W-1:0] x);
      longint xv, pv, d, hp, lp, a, b, lp_old;
      xv     = longint'(x);
      pv     = longint'(last_sample[ch]);
      a      = longint'(active_cfg.high_pass_gain);
      b      = longint'(active_cfg.low_pass_gain);
      lp_old = longint'(lp_acc[ch]);
      d      = xv - pv;
      hp     = longint'(clip32(q16_round((longint'(hp_acc[ch]) + d * 65536) * a)));
      lp     = lp_old + q16_round((hp - lp_old) * b);
      hp_acc[ch] = int'(hp);
      lp_acc[ch] = clip32(lp);
   endfunction

   // add the rounded peak-to-peak span of the window to the lane sum
   function void close_lane(int ch);
      longint span, total;
      span  = longint'(peak_hi[ch]) - longint'(peak_lo[ch]);
      total = longint'(amp_total[ch]) + ((span + 64'sd32768) >>> 16);
      amp_total[ch] = (total > SUM_MAX) ? SUM_MAX : int'(total);
      peak_hi[ch]   = 0;
      peak_lo[ch]   = 0;
   endfunction

   // advance the predictor by one accepted word; queue a detection at block end
   function void track_word(logic [SAMPLE_W-1:0] mic_one, logic [SAMPLE_W-1:0] mic_two);
      logic [SAMPLE_W-1:0] x [LANES];
      int unsigned         n, a1, a2, gap;
      bit                  last;
      detection_type       det;
      n    = word_index;
      last = (n >= BLOCK_LEN - 1);
      x[0] = mic_one;
      x[1] = mic_two;
      for (int ch = 0; ch < LANES; ch++) begin
         if (n >= 1) filter_lane(ch, x[ch]);
         last_sample[ch] = x[ch];
         if (n >= WINDOW_LEN && n < WIN_END) begin
            if (lp_acc[ch] > peak_hi[ch]) peak_hi[ch] = lp_acc[ch];
            if (lp_acc[ch] < peak_lo[ch]) peak_lo[ch] = lp_acc[ch];
            if ((n + 1) % WINDOW_LEN == 0 || last) close_lane(ch);
         end
      end
      if (!last) begin
         word_index = (n + 1) % (1 << IDX_W);
         return;
      end
      a1 = amp_total[0] / 10;
      a2 = amp_total[1] / 10;
      if (a1 > AMP_MAX) a1 = AMP_MAX;
      if (a2 > AMP_MAX) a2 = AMP_MAX;
      det.amp_one       = a1;
      det.amp_two       = a2;
      det.sound_present = (a1 > 32'(active_cfg.detect_level)) ||
                          (a2 > 32'(active_cfg.detect_level));
      det.louder_side   = SIDE_NONE;
      det.turn_degree   = 0;
      gap               = 0;
      if (a2 > a1 + 32'(active_cfg.dead_band)) begin
         det.louder_side = SIDE_TWO;
         gap = a2 - a1;
      end else if (a1 > a2 + 32'(active_cfg.dead_band)) begin
         det.louder_side = SIDE_ONE;
         gap = a1 - a2;
      end
      if (det.louder_side != SIDE_NONE) begin
         if (gap > 32'(active_cfg.degree_step_four)) det.turn_degree = 4;
         else if (gap > 32'(active_cfg.degree_step_three)) det.turn_degree = 3;
         else if (gap > 32'(active_cfg.degree_step_two)) det.turn_degree = 2;
         else if (gap > 32'(active_cfg.degree_step_one)) det.turn_degree = 1;
      end
      pending_detections.push_back(det);
      clear_tracking();
   endfunction

   // ---------------------------------------------------------------- checking

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      detection_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_detections.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("result word with none pending: amp_one %0d amp_two %0d",
                        rsp_bus.amp_one, rsp_bus.amp_two);
         end else begin
            want = pending_detections.pop_front();
            compare_field("amp_one", want.amp_one, 32'(rsp_bus.amp_one));
            compare_field("amp_two", want.amp_two, 32'(rsp_bus.amp_two));
            compare_field("sound_present", 32'(want.sound_present),
                          32'(rsp_bus.sound_present));
            compare_field("louder_side", 32'(want.louder_side), 32'(rsp_bus.louder_side));
            compare_field("turn_degree", want.turn_degree, 32'(rsp_bus.turn_degree));
         end
      end
   end

   // result side: long hold-off when asked, random stalls otherwise
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------- drivers

   // offer one sample word after random idle cycles; returns at a falling edge
   task automatic send_word(input logic [SAMPLE_W-1:0] mic_one,
                            input logic [SAMPLE_W-1:0] mic_two);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.mic_one_sample <= mic_one;
      req_bus.mic_two_sample <= mic_two;
      do @(posedge clock); while (!req_bus.ready);
      track_word(mic_one, mic_two);
      @(negedge clock);
   endtask

   // wait until every detection is in, then let the pipeline settle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_detections.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CFG_W-1:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_HIGH_PASS_GAIN:    active_cfg.high_pass_gain    = value;
         REG_LOW_PASS_GAIN:     active_cfg.low_pass_gain     = value;
         REG_DETECT_LEVEL:      active_cfg.detect_level      = value;
         REG_DEAD_BAND:         active_cfg.dead_band         = value;
         REG_DEGREE_STEP_ONE:   active_cfg.degree_step_one   = value;
         REG_DEGREE_STEP_TWO:   active_cfg.degree_step_two   = value;
         REG_DEGREE_STEP_THREE: active_cfg.degree_step_three = value;
         REG_DEGREE_STEP_FOUR:  active_cfg.degree_step_four  = value;
      endcase
      @(negedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic write_settings(input cfg_type s);
      drain_results();
      write_reg(REG_HIGH_PASS_GAIN, s.high_pass_gain);
      write_reg(REG_LOW_PASS_GAIN, s.low_pass_gain);
      write_reg(REG_DETECT_LEVEL, s.detect_level);
      write_reg(REG_DEAD_BAND, s.dead_band);
      write_reg(REG_DEGREE_STEP_ONE, s.degree_step_one);
      write_reg(REG_DEGREE_STEP_TWO, s.degree_step_two);
      write_reg(REG_DEGREE_STEP_THREE, s.degree_step_three);
      write_reg(REG_DEGREE_STEP_FOUR, s.degree_step_four);
      csr_bus.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- signals

   function automatic tone_type make_tone(int period, int amp, int offset, int noise,
                                          bit square);
      tone_type t;
      t.period = period;
      t.amp    = amp;
      t.offset = offset;
      t.noise  = noise;
      t.phase  = 0;
      t.square = square;
      return t;
   endfunction

   function automatic tone_type random_tone();
      tone_type t;
      t.period = $urandom_range(2, 160);
      t.amp    = $urandom_range(0, (1 << $urandom_range(4, 13)) - 1);
      t.offset = $urandom_range(0, SAMPLE_MAX);
      t.noise  = $urandom_range(0, 1) ? 0 : $urandom_range(0, 64);
      t.phase  = $urandom_range(0, t.period - 1);
      t.square = $urandom_range(0, 1);
      return t;
   endfunction

   function automatic logic [SAMPLE_W-1:0] tone_sample(tone_type t, int n);
      int ph, v;
      ph = (n + t.phase) % t.period;
      if (t.square) v = (2 * ph < t.period) ? t.amp : -t.amp;
      else v = -t.amp + (2 * t.amp * ph) / t.period;
      if (t.noise > 0) v += int'($urandom_range(0, 2 * t.noise)) - t.noise;
      v += t.offset;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v[SAMPLE_W-1:0];
   endfunction

   // one whole block; mirrored blocks carry the same word on both channels
   task automatic send_block(input tone_type one, input tone_type two, input bit mirror);
      logic [SAMPLE_W-1:0] s1, s2;
      for (int n = 0; n < BLOCK_LEN; n++) begin
         s1 = tone_sample(one, n);
         s2 = mirror ? s1 : tone_sample(two, n);
         send_word(s1, s2);
      end
   endtask

   function automatic cfg_type random_settings();
      cfg_type s;
      int      steps [$];
      if ($urandom_range(0, 4) == 0) begin
         s = cfg_type'({$urandom, $urandom, $urandom, $urandom});
      end else begin
         s.high_pass_gain = $urandom_range(0, 2) ? CFG_W'($urandom_range(40000, 65535))
                                                 : CFG_W'($urandom_range(0, 65535));
         s.low_pass_gain  = $urandom_range(0, 2) ? CFG_W'($urandom_range(20000, 65535))
                                                 : CFG_W'($urandom_range(0, 65535));
         s.detect_level   = CFG_W'($urandom_range(0, 3000));
         s.dead_band      = CFG_W'($urandom_range(0, 300));
         repeat (4) steps.push_back($urandom_range(0, 1500));
         steps.sort();
         s.degree_step_one   = CFG_W'(steps[0]);
         s.degree_step_two   = CFG_W'(steps[1]);
         s.degree_step_three = CFG_W'(steps[2]);
         s.degree_step_four  = CFG_W'(steps[3]);
      end
      return s;
   endfunction

   // mostly tone pairs, some noise, some exactly or nearly balanced
   task automatic send_random_block();
      tone_type one, two;
      int       kind;
      kind = $urandom_range(0, 99);
      one  = random_tone();
      two  = random_tone();
      if (kind < 15) begin
         one = make_tone(2, 0, 8192, 8192, 1'b0);
         send_block(one, one, 1'b0);
      end else if (kind < 30) begin
         send_block(one, one, 1'b1);
      end else if (kind < 45) begin
         two       = one;
         two.noise = 0;
         two.amp   = one.amp + int'($urandom_range(0, 400)) - 200;
         if (two.amp < 0) two.amp = 0;
         send_block(one, two, 1'b0);
      end else begin
         send_block(one, two, 1'b0);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      // flat rails: nothing survives the high-pass
      send_block(make_tone(2, 0, 0, 0, 1'b1), make_tone(2, 0, SAMPLE_MAX, 0, 1'b1), 1'b0);
      // full-swing square on channel one, faint tone on channel two
      send_block(make_tone(8, 8192, 8192, 0, 1'b1), make_tone(20, 40, 8000, 0, 1'b0), 1'b0);
      // and the other way round
      send_block(make_tone(20, 40, 8000, 0, 1'b0), make_tone(8, 8192, 8192, 0, 1'b1), 1'b0);
      // identical words on both channels: balanced
      send_block(make_tone(12, 3000, 8192, 0, 1'b0), make_tone(12, 3000, 8192, 0, 1'b0), 1'b1);
      // full-range noise toggles every sample bit
      send_block(make_tone(2, 0, 8192, 8192, 1'b0), make_tone(2, 0, 8192, 8192, 1'b0), 1'b0);
   endtask

   task automatic test_register_extremes();
      cfg_type s;
      // every register at zero
      s = '0;
      write_settings(s);
      send_block(make_tone(10, 6000, 8192, 0, 1'b1), make_tone(30, 500, 4000, 20, 1'b0), 1'b0);
      // every register at full scale
      s = '1;
      write_settings(s);
      send_block(make_tone(10, 6000, 8192, 0, 1'b1), make_tone(30, 500, 4000, 20, 1'b0), 1'b0);
      // detection out of reach, zero thresholds: side and degree without sound
      s                   = CFG_RESET;
      s.detect_level      = '1;
      s.dead_band         = '0;
      s.degree_step_one   = '0;
      s.degree_step_two   = 16'd1;
      s.degree_step_three = 16'd2;
      s.degree_step_four  = 16'd3;
      write_settings(s);
      send_block(make_tone(16, 4000, 8192, 0, 1'b0), make_tone(16, 3900, 8192, 0, 1'b0), 1'b0);
   endtask

   // result side held off for several blocks while words keep coming
   task automatic test_backpressure();
      write_settings(CFG_RESET);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_cycles   = HOLD_CYCLES;
      repeat (3) send_random_block();
      drain_results();
   endtask

   task automatic test_random_blocks();
      int idle_mix  [4] = '{0, 48, 0, 24};
      int stall_mix [4] = '{0, 0, 48, 24};
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct = idle_mix[mode];
         stall_pct     = stall_mix[mode];
         repeat (2) begin
            write_settings(($urandom_range(0, 3) == 0) ? CFG_RESET : random_settings());
            repeat (4) send_random_block();
         end
      end
   endtask

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.mic_one_sample = '0;
      req_bus.mic_two_sample = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.reg_index      = REG_HIGH_PASS_GAIN;
      csr_bus.wr_data        = '0;
      rsp_bus.ready          = 1'b0;
      active_cfg             = CFG_RESET;
      clear_tracking();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_register_extremes();
      test_backpressure();
      test_random_blocks();
      drain_results();

      if (error_count == 0 && pending_detections.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
